### sv/pscd_pkg.sv
`timescale 1ns / 1ps

package pscd_pkg;

    // Phase codes of the transfer sequencer
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_LEN_WR   = 3'd1;
    localparam logic [2:0] PH_LEN_RD   = 3'd2;
    localparam logic [2:0] PH_WRITE    = 3'd3;
    localparam logic [2:0] PH_READ     = 3'd4;
    localparam logic [2:0] PH_READ_END = 3'd5;

    // Action codes reported with every result beat
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_LENGTH  = 3'd1;
    localparam logic [2:0] ACT_FORWARD = 3'd2;
    localparam logic [2:0] ACT_FETCH   = 3'd3;
    localparam logic [2:0] ACT_RDEND   = 3'd4;
    localparam logic [2:0] ACT_SPEED   = 3'd5;
    localparam logic [2:0] ACT_BAD     = 3'd6;

    // Header byte fields
    localparam logic [7:0] SHORT_LEN_MASK = 8'h3f;
    localparam logic [7:0] LONG_HI_MASK   = 8'h1f;
    localparam logic [7:0] LONG_KIND_MASK = 8'he0;
    localparam logic [7:0] HDR_LONG_WR    = 8'h80;
    localparam logic [7:0] HDR_LONG_RD    = 8'ha0;
    localparam logic [7:0] HDR_SLOW       = 8'hc0;
    localparam logic [7:0] HDR_FAST       = 8'hc1;
    localparam logic [1:0] HDR_SHORT_WR   = 2'b00;
    localparam logic [1:0] HDR_SHORT_RD   = 2'b01;

    localparam int COUNT_W = 14;

    typedef struct packed {
        logic       command;
        logic [7:0] port_byte;
        logic       select_level;
    } item_t;

    typedef struct packed {
        logic [2:0]         action;
        logic [7:0]         spi_byte;
        logic [COUNT_W-1:0] remaining;
        logic               speed_fast;
        logic               cs_active;
        logic               last;
    } result_t;

endpackage

### sv/pscd_in_stage.sv
`timescale 1ns / 1ps

module pscd_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  pscd_pkg::item_t in_item,
    input  logic          take,
    output logic          s0_valid,
    output pscd_pkg::item_t s0_item
);
    import pscd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // Accept a new beat whenever the stage is empty or drains this cycle
    assign in_ready   = !valid_reg || take;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign s0_valid = valid_reg;
    assign s0_item  = item_reg;

endmodule

### sv/pscd_decoder.sv
`timescale 1ns / 1ps

module pscd_decoder (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  pscd_pkg::item_t item,
    output pscd_pkg::result_t result
);
    import pscd_pkg::*;

    logic [2:0]         phase_reg, phase_next;
    logic [4:0]         length_high_reg, length_high_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               speed_reg, speed_next;
    logic               select_reg, select_next;

    logic [COUNT_W-1:0] count_dec;
    logic [2:0]         act;
    logic [7:0]         sbyte;
    logic               last_flag;
    logic [7:0]         b;

    assign b         = item.port_byte;
    assign count_dec = (count_reg != '0) ? count_reg - 1'b1 : '0;

    always_comb
    begin
        phase_next       = phase_reg;
        length_high_next = length_high_reg;
        count_next       = count_reg;
        speed_next       = speed_reg;
        select_next      = select_reg;
        act              = ACT_NONE;
        sbyte            = 8'd0;
        last_flag        = 1'b0;
        if (item.command)
        begin
            select_next = !item.select_level;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEN_WR, PH_LEN_RD:
                begin
                    count_next = {1'b0, length_high_reg, b} + 1'b1;
                    phase_next = (phase_reg == PH_LEN_WR) ? PH_WRITE : PH_READ;
                end
                PH_WRITE:
                begin
                    act        = ACT_FORWARD;
                    sbyte      = b;
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        last_flag  = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
                PH_READ:
                begin
                    act        = ACT_FETCH;
                    count_next = count_dec;
                    if (count_dec == '0)
                    begin
                        last_flag  = 1'b1;
                        phase_next = PH_READ_END;
                    end
                end
                PH_READ_END:
                begin
                    act        = ACT_RDEND;
                    count_next = '0;
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    // Idle, and the unused codes: decode a header byte
                    phase_next = PH_IDLE;
                    count_next = '0;
                    priority if (b[7:6] == HDR_SHORT_WR)
                    begin
                        count_next = COUNT_W'(b & SHORT_LEN_MASK) + 1'b1;
                        phase_next = PH_WRITE;
                    end
                    else if (b[7:6] == HDR_SHORT_RD)
                    begin
                        count_next = COUNT_W'(b & SHORT_LEN_MASK) + 1'b1;
                        phase_next = PH_READ;
                    end
                    else if ((b & LONG_KIND_MASK) == HDR_LONG_WR)
                    begin
                        length_high_next = b[4:0] & LONG_HI_MASK[4:0];
                        phase_next       = PH_LEN_WR;
                        act              = ACT_LENGTH;
                    end
                    else if ((b & LONG_KIND_MASK) == HDR_LONG_RD)
                    begin
                        length_high_next = b[4:0] & LONG_HI_MASK[4:0];
                        phase_next       = PH_LEN_RD;
                        act              = ACT_LENGTH;
                    end
                    else if (b == HDR_SLOW || b == HDR_FAST)
                    begin
                        speed_next = b[0];
                        act        = ACT_SPEED;
                    end
                    else
                    begin
                        act = ACT_BAD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            length_high_reg <= '0;
            count_reg       <= '0;
            speed_reg       <= 1'b0;
            select_reg      <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            length_high_reg <= length_high_next;
            count_reg       <= count_next;
            speed_reg       <= speed_next;
            select_reg      <= select_next;
        end
    end

    assign result.action     = act;
    assign result.spi_byte   = sbyte;
    assign result.remaining  = count_next;
    assign result.speed_fast = speed_next;
    assign result.cs_active  = select_next;
    assign result.last       = last_flag;

    a_idle_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> count_reg == '0)
        else $error("idle phase with a nonzero byte count");

    a_phase_known: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_READ_END)
        else $error("phase holds an unused code");

    a_last_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        fire && last_flag |-> (act == ACT_FORWARD || act == ACT_FETCH))
        else $error("last flagged on a non-data beat");

    a_read_end_follows: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !item.command && act == ACT_FETCH && last_flag
        |=> phase_reg == PH_READ_END)
        else $error("final read fetch did not arm the read end");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(8192))
        else $error("byte count beyond the longest transfer");

endmodule

### sv/parallel_spi_command_decoder_core.sv
`timescale 1ns / 1ps

// Adapter-side command decoder of a parallel-port-to-SPI bridge. Each input
// beat is either a host clock strobe carrying the port byte (command = 0) or a
// chip select change (command = 1, select_level low = selected). In idle a
// strobe is decoded as a header: 00xxxxxx short write and 01xxxxxx short read
// of x+1 bytes, 100hhhhh / 101hhhhh followed by a low byte for a long write or
// read of ((h<<8)|low)+1 bytes, 0xC0 slow and 0xC1 fast speed, anything else
// reported as a bad command. During a write each strobe forwards its byte on
// spi_byte; during a read each strobe fetches one byte and one extra strobe
// ends the transfer. Exactly one result beat leaves for every input beat, in
// order. Timing: one beat is taken every clock cycle when out_ready is held
// high. The result is registered: the input register feeds the decode,
// which loads the result register once that slot is free or being drained
// by the consumer. The phase and byte-count registers update once per beat,
// which is what sets that one-beat-per-cycle figure. Chip select changes never
// abort a transfer in progress.
module parallel_spi_command_decoder_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        command,
    input  logic [7:0]                  port_byte,
    input  logic                        select_level,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  action,
    output logic [7:0]                  spi_byte,
    output logic [pscd_pkg::COUNT_W-1:0] remaining,
    output logic                        speed_fast,
    output logic                        cs_active,
    output logic                        last
);
    import pscd_pkg::*;

    item_t   in_item;
    item_t   s0_item;
    logic    s0_valid;
    logic    take;
    result_t step_result;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    assign in_item.command      = command;
    assign in_item.port_byte    = port_byte;
    assign in_item.select_level = select_level;

    // Advance the held beat into the result register when that slot is free
    // or is being emptied by the consumer in this same cycle.
    assign take = s0_valid && (!out_valid_reg || out_ready);

    pscd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .take     (take),
        .s0_valid (s0_valid),
        .s0_item  (s0_item)
    );

    // Decode the beat and update the transfer state only when it advances
    pscd_decoder u_decoder (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (take),
        .item   (s0_item),
        .result (step_result)
    );

    // Hold the result until it is taken; drop the valid once drained
    assign out_valid_next = take || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = result_reg.action;
    assign spi_byte   = result_reg.spi_byte;
    assign remaining  = result_reg.remaining;
    assign speed_fast = result_reg.speed_fast;
    assign cs_active  = result_reg.cs_active;
    assign last       = result_reg.last;

endmodule
